@@ src/battery_charge_cycle_counter_macros.svh @@
// ---------------------------------------------------------------------------
// Battery charge cycle counter assertion macros
// Short forms for the clocked checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_CYCLE_COUNTER_MACROS_SVH
`define BATTERY_CHARGE_CYCLE_COUNTER_MACROS_SVH

// Same-cycle implication under reset.
`define BCCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bccc check failed");

// Next-cycle implication under reset.
`define BCCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bccc check failed");

`endif

@@ src/bccc_pkg.sv @@
// ---------------------------------------------------------------------------
// Battery charge cycle counter package
// Types, widths and constants shared by the block's files.
// ---------------------------------------------------------------------------
`default_nettype none

package bccc_pkg;

	localparam int unsigned VAR_W   = 42;
	localparam int unsigned PC_W    = 43;
	localparam int unsigned DEN_W   = 44;
	localparam int unsigned REM_W   = 46;
	localparam int unsigned QUO_W   = 33;
	localparam int unsigned EST_W   = 20;
	localparam int unsigned CFG_W   = 41;
	localparam int unsigned MUL_A_W = 44;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [VAR_W-1:0] VAR_ONE  = 42'h100_0000_0000;
	localparam logic [VAR_W-1:0] VAR_MAX  = 42'h3FF_FFFF_FFFF;
	localparam logic [QUO_W-1:0] GAIN_ONE = 33'h1_0000_0000;
	localparam logic [EST_W-1:0] EST_MAX  = 20'hF_FFFF;

	localparam logic [7:0] PCT_FULL = 8'd100;
	localparam logic [7:0] BAND_LOW = 8'd70;
	localparam logic [7:0] TOP_LOW  = 8'd90;
	localparam logic [7:0] TOP_HIGH = 8'd100;
	localparam logic [7:0] PCT_SAT  = 8'd255;

	localparam logic [5:0] GAIN_STEPS = 6'd33;
	localparam logic [5:0] PCT_STEPS  = 6'd9;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PROC_VAR   = 3'd0,
		REG_MEAS_VAR   = 3'd1,
		REG_VOLTS_CNT  = 3'd2,
		REG_FULL_SCALE = 3'd3,
		REG_INIT_CYC   = 3'd4,
		REG_INIT_EST   = 3'd5
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAS,
		ST_GAIN_SET,
		ST_GAIN_DIV,
		ST_VAR_LO,
		ST_VAR_HI,
		ST_VAR_SUM,
		ST_EST_LO,
		ST_EST_HI,
		ST_PCT_MUL,
		ST_PCT_SET,
		ST_PCT_DIV,
		ST_FINISH
	} state_t;

	// Divider control from the sequencer
	typedef struct packed {
		logic       start;
		logic [5:0] steps;
	} div_ctl_t;

endpackage

`default_nettype wire

@@ src/bccc_in_if.sv @@
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one ADC sample per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bccc_in_if #(
	parameter int unsigned ADC_BITS = 12
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ src/bccc_out_if.sv @@
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one filtered result per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bccc_out_if;
	logic        valid;
	logic        ready;
	logic [19:0] filtered_voltage;
	logic [7:0]  charge_percent;
	logic [7:0]  cycle_count;
	logic        cycle_done;

	modport source (output valid, output filtered_voltage, output charge_percent,
		output cycle_count, output cycle_done, input ready);
	modport sink (input valid, input filtered_voltage, input charge_percent,
		input cycle_count, input cycle_done, output ready);
endinterface

`default_nettype wire

@@ src/bccc_div.sv @@
// ---------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle; the first step compares without a shift.
// ---------------------------------------------------------------------------
`default_nettype none

module bccc_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  bccc_pkg::div_ctl_t            ctl,
	input  wire  [bccc_pkg::PC_W-1:0]     rem_init,
	input  wire  [bccc_pkg::DEN_W-1:0]    den,
	input  wire  [7:0]                    shin,
	output logic                          busy,
	output logic [bccc_pkg::QUO_W-1:0]    quo
);

	logic                         busy_q;
	logic                         first_q;
	logic [5:0]                   cnt_q;
	logic [bccc_pkg::REM_W-1:0]   rem_q;
	logic [bccc_pkg::DEN_W-1:0]   den_q;
	logic [7:0]                   sh_q;
	logic [bccc_pkg::QUO_W-1:0]   quo_q;
	logic [bccc_pkg::REM_W-1:0]   cand;
	logic                         ge;

	// Candidate remainder and the compare of this step.
	always_comb begin
		cand = first_q ? rem_q : {rem_q[bccc_pkg::REM_W-2:0], sh_q[7]};
		ge   = cand >= {2'b00, den_q};
	end

	// Control: count the steps down while busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			first_q <= 1'b1;
			cnt_q   <= ctl.steps;
		end else if (busy_q) begin
			first_q <= 1'b0;
			cnt_q   <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, shift-in bits and quotient.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= {{(bccc_pkg::REM_W-bccc_pkg::PC_W){1'b0}}, rem_init};
			den_q <= den;
			sh_q  <= shin;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? cand - {2'b00, den_q} : cand;
			if (!first_q) begin
				sh_q <= {sh_q[6:0], 1'b0};
			end
			quo_q <= {quo_q[bccc_pkg::QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ src/battery_charge_cycle_counter.sv @@
// ---------------------------------------------------------------------------
// Battery charge cycle counter
// Scalar Kalman filter on battery voltage samples with charge cycle counting.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Beat carries
//  in_ch    sink       sample
//  out_ch   source     filtered_voltage, charge_percent, cycle_count, cycle_done
//  cfg      write      cfg_index, cfg_data under cfg_we
//
// The serial divider takes 33 steps for the gain and 9 for the percent.
// One 44x17 multiplier is shared for the scaling, the variance, the update
// and the percent. A new sample is taken only once the previous result has
// been loaded into the output register; a stalled result holds that load.
// Reset needs no pass.
//
`default_nettype none
`include "battery_charge_cycle_counter_macros.svh"

module battery_charge_cycle_counter #(
	parameter int unsigned ADC_BITS = 12
) (
	input  wire                       clk,
	input  wire                       arst_n,
	bccc_in_if.sink                   in_ch,
	bccc_out_if.source                out_ch,
	input  wire                       cfg_we,
	input  wire  [2:0]                cfg_index,
	input  wire  [bccc_pkg::CFG_W-1:0] cfg_data
);

	bccc_pkg::state_t state_q, state_d;

	// Configuration registers
	logic [40:0] proc_var_q;
	logic [40:0] meas_var_q;
	logic [15:0] vpc_q;
	logic [19:0] fs_q;

	// Filter state
	logic [bccc_pkg::VAR_W-1:0] var_q;
	logic [19:0]                est_q;
	logic                       band_q;
	logic                       top_q;
	logic [7:0]                 cycles_q;

	// Working registers
	logic [ADC_BITS-1:0]         s_q;
	logic [bccc_pkg::PC_W-1:0]   pc_q;
	logic [19:0]                 mag_q;
	logic                        up_q;
	logic                        den_zero_q;
	logic [bccc_pkg::QUO_W-1:0]  gain_q;
	logic [bccc_pkg::PROD_W-1:0] prod_q;
	logic [bccc_pkg::PROD_W-1:0] acc_q;
	logic [7:0]                  pct_q;

	// Output register
	logic        out_valid_q;
	logic [19:0] out_est_q;
	logic [7:0]  out_pct_q;
	logic [7:0]  out_cyc_q;
	logic        out_done_q;

	// Shared multiplier operands
	logic [bccc_pkg::MUL_A_W-1:0] mul_a;
	logic [bccc_pkg::MUL_B_W-1:0] mul_b;

	// Divider hookup
	bccc_pkg::div_ctl_t          div_ctl;
	logic [bccc_pkg::PC_W-1:0]   div_rem;
	logic [bccc_pkg::DEN_W-1:0]  div_den;
	logic [7:0]                  div_sh;
	logic                        div_busy;
	logic [bccc_pkg::QUO_W-1:0]  div_quo;

	// Combinational helpers
	logic [32:0]                 meas_raw;
	logic [19:0]                 meas_c;
	logic [bccc_pkg::DEN_W-1:0]  den_c;
	logic [bccc_pkg::QUO_W-1:0]  omg;
	logic [bccc_pkg::PROD_W-1:0] var_sum;
	logic [44:0]                 nv;
	logic [53:0]                 est_sum;
	logic [21:0]                 delta;
	logic [20:0]                 est_up;
	logic [19:0]                 est_new;
	logic [26:0]                 pct_prod;
	logic                        band_n;
	logic                        top_n;
	logic                        done_n;
	logic                        out_free;
	logic                        in_fire;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	// Scaled measurement, rounded and clamped to 20 bits.
	always_comb begin
		meas_raw = {1'b0, prod_q[31:0]} + 33'd128;
		meas_c   = (meas_raw[32:8] > {5'd0, bccc_pkg::EST_MAX}) ?
			bccc_pkg::EST_MAX : meas_raw[27:8];
		den_c    = {1'b0, pc_q} + {3'd0, meas_var_q};
		omg      = bccc_pkg::GAIN_ONE - gain_q;
		var_sum  = prod_q + acc_q;
		nv       = var_sum[60:16];
		est_sum  = {prod_q[37:0], 16'd0} + {1'b0, acc_q[52:0]};
		delta    = est_sum[53:32];
		est_up   = {1'b0, est_q} + {1'b0, delta[19:0]};
		pct_prod = prod_q[26:0];
	end

	// New estimate: step towards the measurement, clamped to 20 bits.
	always_comb begin
		if (up_q) begin
			est_new = (est_up[20] || delta[21:20] != 2'd0) ? bccc_pkg::EST_MAX : est_up[19:0];
		end else begin
			est_new = ({2'd0, est_q} < delta) ? 20'd0 : est_q - delta[19:0];
		end
	end

	// Flag update for the finished percent.
	always_comb begin
		band_n = band_q || (pct_q >= bccc_pkg::BAND_LOW && pct_q < bccc_pkg::TOP_LOW);
		top_n  = top_q || (pct_q >= bccc_pkg::TOP_LOW && pct_q <= bccc_pkg::TOP_HIGH);
		done_n = band_n && top_n && pct_q >= bccc_pkg::TOP_LOW;
	end

	// Sequencer: next state, multiplier operands and divider control.
	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		div_ctl.start = 1'b0;
		div_ctl.steps = bccc_pkg::GAIN_STEPS;
		div_rem       = pc_q;
		div_den       = den_c;
		div_sh        = 8'd0;
		in_ch.ready   = 1'b0;
		case (state_q)
			bccc_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = bccc_pkg::ST_MEAS;
				end
			end
			bccc_pkg::ST_MEAS: begin
				mul_a   = {{(bccc_pkg::MUL_A_W-ADC_BITS){1'b0}}, s_q};
				mul_b   = {1'b0, vpc_q};
				state_d = bccc_pkg::ST_GAIN_SET;
			end
			bccc_pkg::ST_GAIN_SET: begin
				div_ctl.start = 1'b1;
				state_d       = bccc_pkg::ST_GAIN_DIV;
			end
			bccc_pkg::ST_GAIN_DIV: begin
				if (!div_busy) begin
					state_d = bccc_pkg::ST_VAR_LO;
				end
			end
			bccc_pkg::ST_VAR_LO: begin
				mul_a   = {1'b0, pc_q};
				mul_b   = {1'b0, omg[15:0]};
				state_d = bccc_pkg::ST_VAR_HI;
			end
			bccc_pkg::ST_VAR_HI: begin
				mul_a   = {1'b0, pc_q};
				mul_b   = omg[32:16];
				state_d = bccc_pkg::ST_VAR_SUM;
			end
			bccc_pkg::ST_VAR_SUM: begin
				mul_a   = {24'd0, mag_q};
				mul_b   = {1'b0, gain_q[15:0]};
				state_d = bccc_pkg::ST_EST_LO;
			end
			bccc_pkg::ST_EST_LO: begin
				mul_a   = {24'd0, mag_q};
				mul_b   = gain_q[32:16];
				state_d = bccc_pkg::ST_EST_HI;
			end
			bccc_pkg::ST_EST_HI: begin
				state_d = bccc_pkg::ST_PCT_MUL;
			end
			bccc_pkg::ST_PCT_MUL: begin
				mul_a   = {24'd0, est_q};
				mul_b   = {9'd0, bccc_pkg::PCT_FULL};
				state_d = bccc_pkg::ST_PCT_SET;
			end
			bccc_pkg::ST_PCT_SET: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = bccc_pkg::PCT_STEPS;
				div_rem       = {24'd0, pct_prod[26:8]};
				div_den       = {24'd0, fs_q};
				div_sh        = pct_prod[7:0];
				state_d       = bccc_pkg::ST_PCT_DIV;
			end
			bccc_pkg::ST_PCT_DIV: begin
				if (!div_busy) begin
					state_d = bccc_pkg::ST_FINISH;
				end
			end
			bccc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = bccc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bccc_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bccc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Shared multiplier with registered product.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Configuration registers and filter state. The initial cycle count and
	// estimate registers act only by loading the filter state when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_var_q <= 41'd10995;
			meas_var_q <= 41'd12334789;
			vpc_q      <= 16'd34477;
			fs_q       <= 20'd550502;
			var_q      <= bccc_pkg::VAR_ONE;
			est_q      <= 20'd0;
			band_q     <= 1'b0;
			top_q      <= 1'b0;
			cycles_q   <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bccc_pkg::REG_PROC_VAR:   proc_var_q <= cfg_data;
					bccc_pkg::REG_MEAS_VAR:   meas_var_q <= cfg_data;
					bccc_pkg::REG_VOLTS_CNT:  vpc_q <= cfg_data[15:0];
					bccc_pkg::REG_FULL_SCALE: fs_q <= cfg_data[19:0];
					bccc_pkg::REG_INIT_CYC: begin
						cycles_q <= cfg_data[7:0];
					end
					bccc_pkg::REG_INIT_EST: begin
						est_q <= cfg_data[19:0];
					end
					default: begin
					end
				endcase
			end
			if (state_q == bccc_pkg::ST_VAR_SUM) begin
				var_q <= (nv > {3'd0, bccc_pkg::VAR_MAX}) ? bccc_pkg::VAR_MAX : nv[41:0];
			end
			if (state_q == bccc_pkg::ST_EST_HI) begin
				est_q <= est_new;
			end
			if (state_q == bccc_pkg::ST_FINISH && out_free) begin
				band_q <= band_n && !done_n;
				top_q  <= top_n && !done_n;
				if (done_n) begin
					cycles_q <= cycles_q + 8'd1;
				end
			end
		end
	end

	// Working registers of one sample.
	always_ff @(posedge clk) begin
		case (state_q)
			bccc_pkg::ST_IDLE: begin
				if (in_fire) begin
					s_q <= in_ch.sample;
				end
			end
			bccc_pkg::ST_MEAS: begin
				pc_q <= {1'b0, var_q} + {2'd0, proc_var_q};
			end
			bccc_pkg::ST_GAIN_SET: begin
				up_q       <= meas_c >= est_q;
				mag_q      <= (meas_c >= est_q) ? meas_c - est_q : est_q - meas_c;
				den_zero_q <= den_c == '0;
			end
			bccc_pkg::ST_GAIN_DIV: begin
				if (!div_busy) begin
					gain_q <= den_zero_q ? '0 : div_quo;
				end
			end
			bccc_pkg::ST_VAR_HI: begin
				acc_q <= {16'd0, prod_q[60:16]};
			end
			bccc_pkg::ST_EST_HI: begin
				acc_q <= '0;
			end
			bccc_pkg::ST_EST_LO: begin
				acc_q <= prod_q + 61'h0_8000_0000;
			end
			bccc_pkg::ST_PCT_DIV: begin
				if (!div_busy) begin
					pct_q <= div_quo[8] ? bccc_pkg::PCT_SAT : div_quo[7:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded at the end of a sample, freed by a beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bccc_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bccc_pkg::ST_FINISH && out_free) begin
			out_est_q  <= est_q;
			out_pct_q  <= pct_q;
			out_cyc_q  <= done_n ? cycles_q + 8'd1 : cycles_q;
			out_done_q <= done_n;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.filtered_voltage = out_est_q;
	assign out_ch.charge_percent   = out_pct_q;
	assign out_ch.cycle_count      = out_cyc_q;
	assign out_ch.cycle_done       = out_done_q;

	bccc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem),
		.den      (div_den),
		.shin     (div_sh),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	// Checks on the sequencer and the datapath.
	`BCCC_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_fire, !in_ch.ready)
	`BCCC_ASSERT_IMPL(a_ready_idle_only, clk, arst_n, state_q != bccc_pkg::ST_IDLE, !in_ch.ready)
	`BCCC_ASSERT_IMPL(a_done_top_pct, clk, arst_n, out_ch.valid && out_ch.cycle_done, out_ch.charge_percent >= bccc_pkg::TOP_LOW)
	`BCCC_ASSERT_IMPL(a_gain_bound, clk, arst_n, state_q == bccc_pkg::ST_VAR_LO, gain_q <= bccc_pkg::GAIN_ONE)

endmodule

`default_nettype wire
